FILE: hdl/windowed_dc_offset_estimator_defines.svh
// Assertion macros for the DC offset estimator.
`ifndef WINDOWED_DC_OFFSET_ESTIMATOR_DEFINES_SVH
`define WINDOWED_DC_OFFSET_ESTIMATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WDC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define WDC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hdl/wdc_pkg.sv
// ----------------------------------------------------------------------------
// wdc_pkg
// Types and constants shared by the DC offset estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package wdc_pkg;
    localparam int ACC_BITS  = 29;
    localparam int LEN_BITS  = 13;
    localparam int MAG_BITS  = 16;
    localparam int TOT_BITS  = 32;
    localparam int WIN_BITS  = 16;
    localparam int SQ_BITS   = 2 * ACC_BITS;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 13'd1024;
    localparam logic FUNC_ROW   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [15:0] re_ant0;
        logic signed [15:0] im_ant0;
        logic signed [15:0] re_ant1;
        logic signed [15:0] im_ant1;
        logic signed [15:0] re_ant2;
        logic signed [15:0] im_ant2;
        logic signed [15:0] re_ant3;
        logic signed [15:0] im_ant3;
    } t_req;

    typedef struct packed {
        logic [1:0]          antenna;
        logic [MAG_BITS-1:0] dc_magnitude;
        logic [MAG_BITS-1:0] mean_magnitude;
        logic [WIN_BITS-1:0] window_number;
        logic                last_of_run;
    } t_res;
endpackage

FILE: hdl/wdc_stream_if.sv
// ----------------------------------------------------------------------------
// wdc_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface wdc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/wdc_lane.sv
// ----------------------------------------------------------------------------
// wdc_lane
// One antenna lane: saturating sums, then close math (divide, square,
// square root); the divide and the root are bit-serial, one bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wdc_lane
    import wdc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_add,
    input  logic signed [15:0]        i_re,
    input  logic signed [15:0]        i_im,
    input  logic                      i_start,
    input  logic [LEN_BITS-1:0]       i_rows,
    output logic                      o_done,
    output logic [MAG_BITS:0]         o_mag
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_DIV = 5'b00010, S_SQ = 5'b00100,
        S_SQRT = 5'b01000, S_DONE = 5'b10000
    } t_state;

    localparam int QB = ACC_BITS - 1;
    localparam int SB = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;

    t_state r_state, n_state;
    logic signed [ACC_BITS-1:0] r_sre, r_sim;
    logic [QB-1:0] r_nre, r_nim;
    logic [QB-1:0] r_qre, r_qim;
    logic [LEN_BITS-1:0] r_rem_re, r_rem_im, r_div;
    logic [5:0] r_cnt;
    logic [SQ_BITS-1:0] r_x;
    logic [SQ_BITS-1:0] r_res, r_bit;

    logic signed [ACC_BITS:0] w_sum_re, w_sum_im;
    logic signed [ACC_BITS-1:0] w_sre, w_sim;
    logic signed [16:0] w_re, w_im;
    logic [LEN_BITS:0] w_tre, w_tim;
    logic [SQ_BITS-1:0] w_trial;
    logic [31:0] w_sq_re, w_sq_im;

    function automatic logic signed [ACC_BITS-1:0] sat(input logic signed [ACC_BITS:0] v);
        logic signed [ACC_BITS-1:0] hi;
        hi = {1'b0, {(ACC_BITS-1){1'b1}}};
        if (v > $signed({1'b0, hi})) return hi;
        if (v < $signed({1'b1, ~hi})) return ~hi;
        return v[ACC_BITS-1:0];
    endfunction

    assign w_re = (SAMPLE_BITS > 16) ? $signed({1'b0, i_re}) : 17'($signed(i_re[SB-1:0]));
    assign w_im = (SAMPLE_BITS > 16) ? $signed({1'b0, i_im}) : 17'($signed(i_im[SB-1:0]));
    assign w_sum_re = (ACC_BITS+1)'(r_sre) + (ACC_BITS+1)'(w_re);
    assign w_sum_im = (ACC_BITS+1)'(r_sim) + (ACC_BITS+1)'(w_im);
    assign w_sre = sat(w_sum_re);
    assign w_sim = sat(w_sum_im);
    assign w_tre = {r_rem_re, r_nre[QB-1]} - {1'b0, r_div};
    assign w_tim = {r_rem_im, r_nim[QB-1]} - {1'b0, r_div};
    assign w_trial = r_res + r_bit;
    assign w_sq_re = r_qre[15:0] * r_qre[15:0];
    assign w_sq_im = r_qim[15:0] * r_qim[15:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_DIV;
            S_DIV:  if (r_cnt == 6'(QB - 1)) n_state = S_SQ;
            S_SQ:   n_state = S_SQRT;
            S_SQRT: if (r_cnt == 6'(SQ_BITS / 2 - 1)) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sre <= '0;
            r_sim <= '0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_sre <= '0;
                r_sim <= '0;
            end else if (i_add) begin
                r_sre <= w_sre;
                r_sim <= w_sim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_nre <= r_sre[ACC_BITS-1] ? QB'(-r_sre) : QB'(r_sre);
                r_nim <= r_sim[ACC_BITS-1] ? QB'(-r_sim) : QB'(r_sim);
                r_rem_re <= '0;
                r_rem_im <= '0;
                r_div <= i_rows;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_nre <= r_nre << 1;
                r_nim <= r_nim << 1;
                if (!w_tre[LEN_BITS]) begin
                    r_rem_re <= w_tre[LEN_BITS-1:0];
                    r_qre <= {r_qre[QB-2:0], 1'b1};
                end else begin
                    r_rem_re <= {r_rem_re[LEN_BITS-2:0], r_nre[QB-1]};
                    r_qre <= {r_qre[QB-2:0], 1'b0};
                end
                if (!w_tim[LEN_BITS]) begin
                    r_rem_im <= w_tim[LEN_BITS-1:0];
                    r_qim <= {r_qim[QB-2:0], 1'b1};
                end else begin
                    r_rem_im <= {r_rem_im[LEN_BITS-2:0], r_nim[QB-1]};
                    r_qim <= {r_qim[QB-2:0], 1'b0};
                end
                r_cnt <= (r_cnt == 6'(QB - 1)) ? '0 : r_cnt + 6'd1;
            end
            S_SQ: begin
                r_x <= SQ_BITS'(w_sq_re) + SQ_BITS'(w_sq_im);
                r_res <= '0;
                r_bit <= SQ_BITS'(1) << (SQ_BITS - 2);
            end
            S_SQRT: begin
                if (r_x >= w_trial) begin
                    r_x <= r_x - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
            end
            S_DONE: begin
                r_cnt <= '0;
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_done = (r_state == S_DONE);
    assign o_mag  = (MAG_BITS+1)'(r_res);
endmodule

FILE: hdl/windowed_dc_offset_estimator.sv
// ----------------------------------------------------------------------------
// windowed_dc_offset_estimator
// Per-antenna windowed DC offset magnitude and its running average.
// ----------------------------------------------------------------------------
// Sample rows are taken one per cycle while no window is closing. When a
// window closes the lanes divide their sums by the row count bit-serially,
// square and take a bit-serial root; the merge stage then divides each
// magnitude total by the window count, one lane at a time, and sends the
// lane results in order. A closing row thus holds the input until every
// lane result has been sent, output stalls included.
`timescale 1ns / 1ps
`include "windowed_dc_offset_estimator_defines.svh"
module windowed_dc_offset_estimator
    import wdc_pkg::*;
#(
    parameter int NUM_LANES   = 4,
    parameter int MAX_WINDOW  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    wdc_stream_if.sink          i_req,
    wdc_stream_if.source        o_res
);
    localparam int LB = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam logic [LEN_BITS:0] MAXW = (LEN_BITS+1)'((MAX_WINDOW > 8191) ? 8191 : MAX_WINDOW);

    typedef enum logic [4:0] {
        S_RUN = 5'b00001, S_CALC = 5'b00010, S_DIV = 5'b00100,
        S_OUT = 5'b01000, S_NEXT = 5'b10000
    } t_state;

    t_state r_state;
    logic [LEN_BITS-1:0] r_len, r_rows;
    logic [WIN_BITS-1:0] r_win;
    logic r_sat;
    logic [TOT_BITS-1:0] r_tot [NUM_LANES];
    logic [MAG_BITS:0]   r_mag [NUM_LANES];
    logic [NUM_LANES-1:0] r_done;
    logic [LB-1:0] r_lane;
    logic [TOT_BITS-1:0] r_num, r_q;
    logic [WIN_BITS:0] r_rem;
    logic [5:0] r_cnt;

    logic w_acc, w_row, w_flush, w_close, w_start;
    logic [LEN_BITS-1:0] w_rows1, w_eff;
    logic [WIN_BITS+1:0] w_t;
    logic [NUM_LANES-1:0] w_ldone;
    logic [MAG_BITS:0] w_lmag [NUM_LANES];
    logic signed [15:0] w_re [NUM_LANES];
    logic signed [15:0] w_im [NUM_LANES];

    assign i_req.ready = (r_state == S_RUN);
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_row   = w_acc && (i_req.data.func == FUNC_ROW);
    assign w_flush = w_acc && (i_req.data.func == FUNC_FLUSH) && (r_rows != '0);
    assign w_rows1 = (r_rows == '1) ? r_rows : r_rows + 1'b1;
    always_comb begin
        if (r_len == '0) w_eff = LEN_BITS'(1);
        else if ({1'b0, r_len} > MAXW) w_eff = MAXW[LEN_BITS-1:0];
        else w_eff = r_len;
    end
    assign w_close = w_flush || (w_row && (w_rows1 >= w_eff));
    assign w_start = (r_state == S_CALC);

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            w_re[k] = '0;
            w_im[k] = '0;
        end
        w_re[0] = i_req.data.re_ant0; w_im[0] = i_req.data.im_ant0;
        if (NUM_LANES > 1) begin w_re[1 % NUM_LANES] = i_req.data.re_ant1;
            w_im[1 % NUM_LANES] = i_req.data.im_ant1; end
        if (NUM_LANES > 2) begin w_re[2 % NUM_LANES] = i_req.data.re_ant2;
            w_im[2 % NUM_LANES] = i_req.data.im_ant2; end
        if (NUM_LANES > 3) begin w_re[3 % NUM_LANES] = i_req.data.re_ant3;
            w_im[3 % NUM_LANES] = i_req.data.im_ant3; end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        wdc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .i_clk, .i_rst_n,
            .i_add(w_row), .i_re(w_re[g]), .i_im(w_im[g]),
            .i_start(w_start), .i_rows(r_rows),
            .o_done(w_ldone[g]), .o_mag(w_lmag[g])
        );
    end

    assign w_t = {r_rem, r_num[TOT_BITS-1]} - {2'b0, r_win};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_len <= LEN_RESET;
            r_rows <= '0;
            r_win <= '0;
            r_done <= '0;
            r_lane <= '0;
            r_cnt <= '0;
            o_res.valid <= 1'b0;
            for (int k = 0; k < NUM_LANES; k++) r_tot[k] <= '0;
        end else begin
            if (i_cfg_we) r_len <= i_cfg_data;
            unique case (r_state)
                S_RUN: begin
                    if (w_row) r_rows <= w_rows1;
                    if (w_close) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_DIV;
                    r_done <= '0;
                    r_sat <= (r_win == '1);
                    if (r_win != '1) r_win <= r_win + 1'b1;
                    r_lane <= '0;
                    r_cnt <= 6'd63;
                end
                S_DIV: begin
                    for (int k = 0; k < NUM_LANES; k++)
                        if (w_ldone[k]) begin
                            r_mag[k] <= w_lmag[k];
                            r_done[k] <= 1'b1;
                            if (!r_sat)
                                r_tot[k] <= (({1'b0, r_tot[k]} + 33'(w_lmag[k])) > 33'hFFFFFFFF)
                                    ? '1 : r_tot[k] + TOT_BITS'(w_lmag[k]);
                        end
                    if (r_cnt == 6'd63) begin
                        if (&r_done) begin
                            r_num <= r_tot[r_lane];
                            r_rem <= '0;
                            r_cnt <= '0;
                        end
                    end else begin
                        r_num <= r_num << 1;
                        if (!w_t[WIN_BITS+1]) begin
                            r_rem <= w_t[WIN_BITS:0];
                            r_q <= {r_q[TOT_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[WIN_BITS-1:0], r_num[TOT_BITS-1]};
                            r_q <= {r_q[TOT_BITS-2:0], 1'b0};
                        end
                        if (r_cnt == 6'(TOT_BITS - 1)) begin
                            r_state <= S_OUT;
                            r_cnt <= 6'd63;
                        end else r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: begin
                    o_res.valid <= 1'b1;
                    o_res.data.antenna <= 2'(r_lane);
                    o_res.data.dc_magnitude <= r_mag[r_lane][MAG_BITS-1:0];
                    o_res.data.mean_magnitude <= r_q[MAG_BITS-1:0];
                    o_res.data.window_number <= r_win;
                    o_res.data.last_of_run <= (r_lane == LB'(NUM_LANES - 1));
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (o_res.ready) begin
                        o_res.valid <= 1'b0;
                        if (r_lane == LB'(NUM_LANES - 1)) begin
                            r_state <= S_RUN;
                            r_rows <= '0;
                        end else begin
                            r_lane <= r_lane + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    `WDC_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, r_state != S_RUN, !i_req.ready)
    `WDC_ASSERT_IMPL(a_valid_out, i_clk, i_rst_n, o_res.valid, r_state == S_NEXT)
    `WDC_ASSERT_NEXT(a_close_calc, i_clk, i_rst_n, w_close, r_state == S_CALC)
endmodule

FILE: tb/tb_windowed_dc_offset_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_dc_offset_estimator
// Self-checking bench for the windowed DC offset estimator. Sample rows and
// flush requests go in over the request channel with random gaps; a local
// model of the per-antenna sums, window count and magnitude totals predicts
// every lane result, which is checked in order as it leaves the block.
// ----------------------------------------------------------------------------
module tb_windowed_dc_offset_estimator
    import wdc_pkg::*;
();

    localparam int LANES      = 4;
    localparam int SETTLE     = 400;
    localparam int STALL_CAP  = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [LEN_BITS-1:0] i_cfg_data;

    wdc_stream_if #(.T(t_req)) req_if ();
    wdc_stream_if #(.T(t_res)) res_if ();

    windowed_dc_offset_estimator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    // estimator state
    longint        acc_re [LANES];
    longint        acc_im [LANES];
    int unsigned   row_count;
    int unsigned   closed_windows;
    longint        mag_total [LANES];
    logic [LEN_BITS-1:0] win_len;

    t_res   pending_results [$];
    int     error_count;
    int     rows_sent;
    int     flushes_sent;
    int     results_seen;
    int     send_gap_max;
    int     recv_gap_max;
    int     next_gap;
    int     idle_cycles;
    bit     hold_recv;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint isqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= root + b) begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint clamp_acc(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (ACC_BITS - 1)) - 1;
        lo = -(longint'(1) << (ACC_BITS - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void close_window();
        bit     frozen;
        longint mr;
        longint mi;
        longint mag;
        t_res   r;
        frozen = (closed_windows >= 16'hFFFF);
        if (!frozen) closed_windows++;
        for (int k = 0; k < LANES; k++) begin
            mr = acc_re[k] / longint'(row_count);
            mi = acc_im[k] / longint'(row_count);
            if (mr < 0) mr = -mr;
            if (mi < 0) mi = -mi;
            mag = isqrt(mr * mr + mi * mi);
            if (!frozen) begin
                mag_total[k] = mag_total[k] + mag;
                if (mag_total[k] > 64'hFFFF_FFFF) mag_total[k] = 64'hFFFF_FFFF;
            end
            r.antenna        = k[1:0];
            r.dc_magnitude   = mag[15:0];
            r.mean_magnitude = 16'(mag_total[k] / closed_windows);
            r.window_number  = closed_windows[15:0];
            r.last_of_run    = (k == LANES - 1);
            pending_results.push_back(r);
            acc_re[k] = 0;
            acc_im[k] = 0;
        end
        row_count = 0;
    endfunction

    function automatic void predict_request(t_req q);
        longint re [LANES];
        longint im [LANES];
        int unsigned eff;
        if (q.func == FUNC_FLUSH) begin
            if (row_count != 0) close_window();
            return;
        end
        re[0] = q.re_ant0; im[0] = q.im_ant0;
        re[1] = q.re_ant1; im[1] = q.im_ant1;
        re[2] = q.re_ant2; im[2] = q.im_ant2;
        re[3] = q.re_ant3; im[3] = q.im_ant3;
        for (int k = 0; k < LANES; k++) begin
            acc_re[k] = clamp_acc(acc_re[k] + re[k]);
            acc_im[k] = clamp_acc(acc_im[k] + im[k]);
        end
        if (row_count < 13'h1FFF) row_count++;
        eff = (win_len == 0) ? 1 : (win_len > 4096 ? 4096 : win_len);
        if (row_count >= eff) close_window();
    endfunction

    task automatic send_request(t_req q);
        repeat (next_gap) @(posedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(q);
        if (q.func == FUNC_FLUSH) flushes_sent++;
        else rows_sent++;
        next_gap = $urandom_range(0, send_gap_max);
        if (next_gap > 0) req_if.valid <= 1'b0;
    endtask

    task automatic drain();
        if (next_gap == 0) begin
            next_gap = 1;
            req_if.valid <= 1'b0;
        end
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(int unsigned len);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len[LEN_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        win_len = len[LEN_BITS-1:0];
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req make_row(logic signed [15:0] re, logic signed [15:0] im);
        t_req q;
        q.func = FUNC_ROW;
        q.re_ant0 = re;  q.im_ant0 = im;
        q.re_ant1 = -re; q.im_ant1 = im;
        q.re_ant2 = im;  q.im_ant2 = re;
        q.re_ant3 = re;  q.im_ant3 = -im;
        return q;
    endfunction

    function automatic t_req random_row();
        t_req q;
        q = '0;
        q.func = FUNC_ROW;
        q.re_ant0 = pick_sample(); q.im_ant0 = pick_sample();
        q.re_ant1 = pick_sample(); q.im_ant1 = pick_sample();
        q.re_ant2 = pick_sample(); q.im_ant2 = pick_sample();
        q.re_ant3 = pick_sample(); q.im_ant3 = pick_sample();
        return q;
    endfunction

    function automatic t_req flush_request();
        t_req q;
        q = random_row();
        q.func = FUNC_FLUSH;
        return q;
    endfunction

    // result checker
    initial begin
        t_res got;
        t_res want;
        int   gap;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_recv) begin
                res_if.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_recv = 1'b0;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            got = res_if.data;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result antenna %0d", $time, got.antenna);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.antenna !== want.antenna) begin
                    $display("%0t: antenna exp %0d got %0d", $time, want.antenna, got.antenna);
                    error_count++;
                end
                if (got.dc_magnitude !== want.dc_magnitude) begin
                    $display("%0t: dc_magnitude exp %0d got %0d", $time,
                             want.dc_magnitude, got.dc_magnitude);
                    error_count++;
                end
                if (got.mean_magnitude !== want.mean_magnitude) begin
                    $display("%0t: mean_magnitude exp %0d got %0d", $time,
                             want.mean_magnitude, got.mean_magnitude);
                    error_count++;
                end
                if (got.window_number !== want.window_number) begin
                    $display("%0t: window_number exp %0d got %0d", $time,
                             want.window_number, got.window_number);
                    error_count++;
                end
                if (got.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run exp %0d got %0d", $time,
                             want.last_of_run, got.last_of_run);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_CAP) begin
                $display("%0t: no progress, %0d results outstanding", $time,
                         pending_results.size());
                $display("[windowed_dc_offset_estimator] ERROR");
                $finish;
            end
        end
    end

    task automatic test_directed();
        write_length(4);
        send_request(flush_request());
        send_request(make_row(16'sh7FFF, 16'sh7FFF));
        send_request(make_row(16'sh7FFF, 16'sh8000));
        send_request(make_row(16'sh8000, 16'sh8000));
        send_request(make_row(16'sh0001, 16'shFFFF));
        send_request(make_row(16'sh8000, 16'sh8000));
        send_request(flush_request());
        send_request(flush_request());
        send_request(make_row(16'sh1234, 16'shEDCB));
        send_request(make_row(16'shFFFF, 16'sh0000));
        send_request(make_row(16'sh0003, 16'sh0000));
        send_request(flush_request());
        write_length(0);
        send_request(make_row(16'sh7FFF, 16'sh8000));
        send_request(make_row(16'sh0000, 16'sh0000));
        write_length(1);
        send_request(make_row(16'shFFFF, 16'sh8001));
        send_request(flush_request());
    endtask

    task automatic test_length_lowered();
        write_length(8);
        repeat (5) send_request(random_row());
        write_length(3);
        send_request(random_row());
        write_length(2);
        send_request(random_row());
        send_request(random_row());
    endtask

    task automatic test_output_stall();
        write_length(1);
        hold_recv = 1'b1;
        repeat (12) send_request(random_row());
    endtask

    task automatic test_longest_window();
        write_length(8191);
        send_gap_max = 0;
        next_gap = 0;
        repeat (6) send_request(make_row(16'sh7FFF, 16'sh8000));
        send_request(flush_request());
        send_gap_max = 12;
    endtask

    task automatic test_random_traffic();
        int lens [6] = '{1, 2, 3, 5, 16, 4096};
        for (int phase = 0; phase < 6; phase++) begin
            write_length(lens[phase] == 4096 ? 7 : lens[phase]);
            send_gap_max = (phase == 2) ? 0 : 12;
            recv_gap_max = (phase == 3) ? 0 : 12;
            repeat (10) begin
                if ($urandom_range(0, 9) == 0) send_request(flush_request());
                else send_request(random_row());
            end
            if (phase == 4) begin
                wait (pending_results.size() == 0);
            end
        end
        send_request(flush_request());
    endtask

    initial begin
        error_count    = 0;
        rows_sent      = 0;
        flushes_sent   = 0;
        results_seen   = 0;
        send_gap_max   = 12;
        recv_gap_max   = 12;
        next_gap       = 0;
        idle_cycles    = 0;
        hold_recv      = 1'b0;
        row_count      = 0;
        closed_windows = 0;
        win_len        = LEN_RESET;
        for (int k = 0; k < LANES; k++) begin
            acc_re[k] = 0;
            acc_im[k] = 0;
            mag_total[k] = 0;
        end
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_length_lowered();
        test_output_stall();
        test_longest_window();
        test_random_traffic();

        drain();
        $display("covered %0d sample rows and %0d flushes, %0d lane results checked",
                 rows_sent, flushes_sent, results_seen);
        $display("window lengths 0 to 16 and above the maximum, empty and partial flushes,");
        $display("output hold-off and input pause");
        if (error_count == 0) begin
            $display("[windowed_dc_offset_estimator] OK");
        end else begin
            $display("[windowed_dc_offset_estimator] ERROR");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/wdc_pkg.sv
hdl/wdc_stream_if.sv
hdl/wdc_lane.sv
hdl/windowed_dc_offset_estimator.sv
tb/tb_windowed_dc_offset_estimator.sv
